// File: rtl/core/sha256_byte_stream_hasher_core_macros.svh
// Assertion macros used by the SHA-256 hasher top level
`ifndef SHA256_BYTE_STREAM_HASHER_CORE_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SHABSH_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("shabsh assertion failed");

// Next-cycle implication, disabled while in reset
`define SHABSH_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("shabsh assertion failed");

`endif

// File: rtl/core/shabsh_pkg.sv
// Types, constants and tables of the SHA-256 byte stream hasher
package shabsh_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [1:0] CMD_ABSORB        = 2'd0;
    localparam logic [1:0] CMD_ABSORB_FINISH = 2'd1;
    localparam logic [1:0] CMD_FINISH        = 2'd2;
    localparam logic [1:0] CMD_UNUSED        = 2'd3;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // Classified operation handed from the front queue to the engine
    typedef struct packed {
        logic       has_byte;
        logic       finish;
        logic [7:0] data_byte;
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEED,
        ST_COMPRESS,
        ST_UPDATE,
        ST_EMIT
    } eng_state_t;

    typedef enum logic [2:0] {
        PH_MSG,
        PH_MARK,
        PH_ZERO,
        PH_LEN,
        PH_OUT
    } pad_phase_t;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] r;
        case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] r;
        case (idx)
            6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;
            default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/shabsh_front.sv
// Front end: accepts input transfers, decodes the command and queues operations
module shabsh_front #(
    parameter int DEPTH = shabsh_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  shabsh_pkg::in_item_t in_data,
    output logic                 op_valid,
    input  logic                 op_ready,
    output shabsh_pkg::op_t      op
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    shabsh_pkg::op_t  q_mem [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    shabsh_pkg::op_t  op_in;
    logic             push;
    logic             pop;

    always_comb
    begin
        op_in.has_byte  = (in_data.command == shabsh_pkg::CMD_ABSORB) ||
                          (in_data.command == shabsh_pkg::CMD_ABSORB_FINISH);
        op_in.finish    = (in_data.command == shabsh_pkg::CMD_ABSORB_FINISH) ||
                          (in_data.command == shabsh_pkg::CMD_FINISH);
        op_in.data_byte = in_data.data_byte;
    end

    assign in_ready = (cnt_reg != FULL_CNT);
    // unused command is taken and dropped
    assign push     = in_valid && in_ready && (in_data.command != shabsh_pkg::CMD_UNUSED);
    assign op_valid = (cnt_reg != '0);
    assign pop      = op_valid && op_ready;
    assign op       = q_mem[head_reg];

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + PTR_W'(1);
        end
        if (pop)
        begin
            head_next = (head_reg == LAST_PTR) ? '0 : head_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[tail_reg] <= op_in;
        end
    end

endmodule

// File: rtl/core/shabsh_engine.sv
// Back end: block buffer, padding sequencer, round-per-cycle compression, digest output
module shabsh_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  op_valid,
    output logic                  op_ready,
    input  shabsh_pkg::op_t       op,
    output logic                  out_valid,
    input  logic                  out_ready,
    output shabsh_pkg::out_item_t out_data
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    shabsh_pkg::eng_state_t state_reg, state_next;
    shabsh_pkg::pad_phase_t phase_reg, phase_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] count_reg, count_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  len_idx_reg, len_idx_next;
    logic [2:0]  emit_idx_reg, emit_idx_next;
    logic [31:0] hash_reg [8];
    logic [31:0] hash_next [8];
    logic        out_valid_reg, out_valid_next;
    shabsh_pkg::out_item_t out_data_reg, out_data_next;

    // w_reg is the block buffer while filling and the schedule window while compressing
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];

    logic        byte_we;
    logic [7:0]  byte_val;
    logic [4:0]  lane_lsb;
    logic        load_v;
    logic [63:0] len_shift;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;

    assign lane_lsb  = {~fill_reg[1:0], 3'b000};
    assign len_shift = {count_reg, 3'b000} << {len_idx_reg, 3'b000};

    always_comb
    begin
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + shabsh_pkg::round_k(rnd_reg) + w_reg[0];
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        w_new = w_reg[0] + w_reg[9]
              + (rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3))
              + (rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10));
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        rnd_next       = rnd_reg;
        len_idx_next   = len_idx_reg;
        emit_idx_next  = emit_idx_reg;
        for (int i = 0; i < 8; i++)
        begin
            hash_next[i] = hash_reg[i];
        end
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        op_ready       = 1'b0;
        byte_we        = 1'b0;
        byte_val       = '0;

        unique case (state_reg)
            shabsh_pkg::ST_IDLE:
            begin
                op_ready = 1'b1;
                if (op_valid)
                begin
                    if (op.has_byte)
                    begin
                        byte_we    = 1'b1;
                        byte_val   = op.data_byte;
                        count_next = count_reg + 61'd1;
                    end
                    if (op.finish)
                    begin
                        phase_next = shabsh_pkg::PH_MARK;
                    end
                    if (op.has_byte && fill_reg == 6'd63)
                    begin
                        state_next = shabsh_pkg::ST_COMPRESS;
                    end
                    else if (op.finish)
                    begin
                        state_next = shabsh_pkg::ST_FEED;
                    end
                end
            end
            shabsh_pkg::ST_FEED:
            begin
                unique case (phase_reg)
                    shabsh_pkg::PH_MARK:
                    begin
                        byte_we    = 1'b1;
                        byte_val   = shabsh_pkg::PAD_MARK;
                        phase_next = shabsh_pkg::PH_ZERO;
                    end
                    shabsh_pkg::PH_ZERO:
                    begin
                        if (fill_reg == shabsh_pkg::LEN_START)
                        begin
                            phase_next = shabsh_pkg::PH_LEN;
                        end
                        else
                        begin
                            byte_we = 1'b1;
                        end
                    end
                    shabsh_pkg::PH_LEN:
                    begin
                        byte_we      = 1'b1;
                        byte_val     = len_shift[63:56];
                        len_idx_next = len_idx_reg + 3'd1;
                        if (len_idx_reg == 3'd7)
                        begin
                            phase_next = shabsh_pkg::PH_OUT;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
                if (byte_we && fill_reg == 6'd63)
                begin
                    state_next = shabsh_pkg::ST_COMPRESS;
                end
            end
            shabsh_pkg::ST_COMPRESS:
            begin
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = shabsh_pkg::ST_UPDATE;
                end
            end
            shabsh_pkg::ST_UPDATE:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + v_reg[i];
                end
                if (phase_reg == shabsh_pkg::PH_MSG)
                begin
                    state_next = shabsh_pkg::ST_IDLE;
                end
                else if (phase_reg == shabsh_pkg::PH_OUT)
                begin
                    state_next = shabsh_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = shabsh_pkg::ST_FEED;
                end
            end
            shabsh_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.digest_word = hash_reg[emit_idx_reg];
                    out_data_next.word_index  = emit_idx_reg;
                    out_data_next.last_word   = (emit_idx_reg == 3'd7);
                    emit_idx_next             = emit_idx_reg + 3'd1;
                    if (emit_idx_reg == 3'd7)
                    begin
                        // message done: back to the initial vector
                        for (int i = 0; i < 8; i++)
                        begin
                            hash_next[i] = shabsh_pkg::init_hash(3'(i));
                        end
                        count_next = '0;
                        phase_next = shabsh_pkg::PH_MSG;
                        state_next = shabsh_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = shabsh_pkg::ST_IDLE;
            end
        endcase

        if (byte_we)
        begin
            fill_next = fill_reg + 6'd1;
        end
    end

    assign load_v = (state_next == shabsh_pkg::ST_COMPRESS) &&
                    (state_reg != shabsh_pkg::ST_COMPRESS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shabsh_pkg::ST_IDLE;
            phase_reg     <= shabsh_pkg::PH_MSG;
            fill_reg      <= '0;
            count_reg     <= '0;
            rnd_reg       <= '0;
            len_idx_reg   <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= shabsh_pkg::init_hash(3'(i));
            end
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            rnd_reg       <= rnd_next;
            len_idx_reg   <= len_idx_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= hash_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (byte_we)
        begin
            w_reg[fill_reg[5:2]][lane_lsb +: 8] <= byte_val;
        end
        else if (state_reg == shabsh_pkg::ST_COMPRESS)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
        if (load_v)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= hash_reg[i];
            end
        end
        else if (state_reg == shabsh_pkg::ST_COMPRESS)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/core/sha256_byte_stream_hasher_core.sv
// Top level of the SHA-256 byte stream hasher
// SHA-256 over a byte stream, one message byte per input transfer. A queue of QUEUE_DEPTH
// operations sits in front of the hashing engine, so up to QUEUE_DEPTH operations are
// queued while the engine is busy; after that in_ready stays low until the engine is idle
// again. The engine takes one byte per cycle into its 64-byte block buffer while idle;
// every full block is then compressed in 64 rounds at one round per cycle plus the
// feed-forward add, with no bytes taken meanwhile. A finish adds padding (mark byte, zero
// bytes up to the length field, eight-byte bit length; one byte per cycle with a pause
// before the length field), one or two compressions, and then eight digest-word transfers,
// word 0 first, the last one flagged. Command 3 is accepted and discarded. After the eighth
// word the engine is back at the initial hash value with an empty buffer and a zero byte count.
`include "sha256_byte_stream_hasher_core_macros.svh"

module sha256_byte_stream_hasher_core #(
    parameter int QUEUE_DEPTH = shabsh_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  shabsh_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output shabsh_pkg::out_item_t out_data
);

    logic            op_valid;
    logic            op_ready;
    shabsh_pkg::op_t op;

    shabsh_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    shabsh_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `SHABSH_ASSERT_IMP(a_last_flag, clk, rst_n, out_valid, out_data.last_word == (out_data.word_index == 3'd7))
    `SHABSH_ASSERT_IMP(a_word_order, clk, rst_n, (out_valid && out_ready && !out_data.last_word) ##1 out_valid, out_data.word_index == $past(out_data.word_index) + 3'd1)
    `SHABSH_ASSERT_NXT(a_gap_after_last, clk, rst_n, out_valid && out_ready && out_data.last_word, !out_valid)

endmodule
